>>> sv/vn3_pkg.sv
// vn3_pkg: shared constants, types and helper functions of the 3d value noise block
// weight table is built at elaboration from an integer sine series
// no dependencies
package vn3_pkg;

  localparam int LATTICE_DIM    = 32;
  localparam int MAX_OCTAVES    = 8;
  localparam int COS_TABLE_BITS = 8;

  localparam int WEIGHT_COUNT = 1 << COS_TABLE_BITS;
  localparam int POS_W        = 8;
  localparam int VAL_W        = 16;
  localparam int AMP_W        = 17;
  localparam int W_W          = 17;
  localparam int OC_W         = 4;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int IDX_W        = $clog2(LATTICE_DIM);
  localparam int OCT_W        = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int SC_W         = POS_W + MAX_OCTAVES - 1 + 16;
  localparam int ACC_GROW     = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int SUM_W        = AMP_W + VAL_W + ACC_GROW + 1;
  localparam int TOT_W        = AMP_W + ACC_GROW + 1;
  localparam int PROD_W       = AMP_W + VAL_W;
  localparam int LD_HALF      = (LATTICE_DIM + 1) / 2;
  localparam int BANK_DEPTH   = LD_HALF * LD_HALF * LD_HALF;
  localparam int BANK_AW      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int DIV_STAGES   = VAL_W;

  localparam logic [AMP_W-1:0] ONE_Q16 = AMP_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVES  = 2'd0,
    CFG_PERSIST  = 2'd1,
    CFG_INV_STEP = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OPC_WRITE = 1'b0,
    OPC_EVAL  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [AMP_W-1:0] amp;
  } oct_ctl_t;

  typedef logic [W_W-1:0] wrom_t [WEIGHT_COUNT];

  function automatic logic [W_W-1:0] weight_entry(input int n);
    logic [63:0] ang;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] w;
    ang  = (64'd1686629713 * 64'(n)) >> COS_TABLE_BITS;
    a2   = (ang * ang) >> 30;
    term = ang;
    s    = ang;
    term = ((term * a2) >> 30) / 64'd6;
    s    = (s >= term) ? s - term : 64'd0;
    term = ((term * a2) >> 30) / 64'd20;
    s    = s + term;
    term = ((term * a2) >> 30) / 64'd42;
    s    = (s >= term) ? s - term : 64'd0;
    term = ((term * a2) >> 30) / 64'd72;
    s    = s + term;
    term = ((term * a2) >> 30) / 64'd110;
    s    = (s >= term) ? s - term : 64'd0;
    term = ((term * a2) >> 30) / 64'd156;
    s    = s + term;
    term = ((term * a2) >> 30) / 64'd210;
    s    = (s >= term) ? s - term : 64'd0;
    w    = (s * s + (64'd1 << 43)) >> 44;
    return (w > 64'd65536) ? ONE_Q16 : W_W'(w);
  endfunction

  function automatic wrom_t build_wrom();
    wrom_t t;
    for (int n = 0; n < WEIGHT_COUNT; n++) begin
      t[n] = weight_entry(n);
    end
    return t;
  endfunction

  localparam wrom_t WROM = build_wrom();

  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b,
                                             input logic [W_W-1:0]   w);
    logic [W_W-1:0]     wc;
    logic [VAL_W+17:0]  t;
    wc = ONE_Q16 - w;
    t  = (VAL_W+18)'(a) * (VAL_W+18)'(wc) + (VAL_W+18)'(b) * (VAL_W+18)'(w)
         + (VAL_W+18)'(32768);
    return t[VAL_W+15:16];
  endfunction

endpackage

>>> sv/vn3_lattice.sv
// vn3_lattice: lattice store split into eight banks by index parity
// one write and eight registered corner reads per cycle while adv is high; uses vn3_pkg
module vn3_lattice (
  input  logic                        clk,
  input  logic                        adv,
  input  logic                        we,
  input  logic [vn3_pkg::POS_W-1:0]   wr_x,
  input  logic [vn3_pkg::POS_W-1:0]   wr_y,
  input  logic [vn3_pkg::POS_W-1:0]   wr_z,
  input  logic [vn3_pkg::VAL_W-1:0]   wr_data,
  input  logic [vn3_pkg::IDX_W-1:0]   lo [3],
  input  logic [vn3_pkg::IDX_W-1:0]   hi [3],
  output logic [vn3_pkg::VAL_W-1:0]   corner [8]
);
  import vn3_pkg::*;

  function automatic logic [BANK_AW-1:0] bank_addr(input logic [IDX_W-1:0] i,
                                                   input logic [IDX_W-1:0] j,
                                                   input logic [IDX_W-1:0] k);
    return BANK_AW'((int'(k >> 1) * LD_HALF + int'(j >> 1)) * LD_HALF + int'(i >> 1));
  endfunction

  logic                 in_range;
  logic [IDX_W-1:0]     wi;
  logic [IDX_W-1:0]     wj;
  logic [IDX_W-1:0]     wk;
  logic [2:0]           wbank;
  logic [BANK_AW-1:0]   waddr;
  logic [VAL_W-1:0]     rd_r [8];
  logic [2:0]           sel_r [8];

  assign in_range = (int'(wr_x) < LATTICE_DIM) && (int'(wr_y) < LATTICE_DIM)
                    && (int'(wr_z) < LATTICE_DIM);
  assign wi    = IDX_W'(wr_x);
  assign wj    = IDX_W'(wr_y);
  assign wk    = IDX_W'(wr_z);
  assign wbank = {wk[0], wj[0], wi[0]};
  assign waddr = bank_addr(wi, wj, wk);

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [VAL_W-1:0]   mem [BANK_DEPTH];
    logic [IDX_W-1:0]   xi;
    logic [IDX_W-1:0]   yi;
    logic [IDX_W-1:0]   zi;
    logic [BANK_AW-1:0] raddr;

    assign xi    = (lo[0][0] == b[0]) ? lo[0] : hi[0];
    assign yi    = (lo[1][0] == b[1]) ? lo[1] : hi[1];
    assign zi    = (lo[2][0] == b[2]) ? lo[2] : hi[2];
    assign raddr = bank_addr(xi, yi, zi);

    always_ff @(posedge clk) begin
      if (we && in_range && (wbank == 3'(b))) begin
        mem[waddr] <= wr_data;
      end
      if (adv) begin
        rd_r[b] <= mem[raddr];
      end
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_corner
    always_ff @(posedge clk) begin
      if (adv) begin
        sel_r[c] <= {c[2] ? hi[2][0] : lo[2][0],
                     c[1] ? hi[1][0] : lo[1][0],
                     c[0] ? hi[0][0] : lo[0][0]};
      end
    end
    assign corner[c] = rd_r[sel_r[c]];
  end

endmodule

>>> sv/vn3_interp.sv
// vn3_interp: trilinear cosine blend in three stages and the amplitude product
// uses vn3_pkg blend function and octave control struct
module vn3_interp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  vn3_pkg::oct_ctl_t           ctl_in,
  input  logic [vn3_pkg::VAL_W-1:0]   corner [8],
  input  logic [vn3_pkg::W_W-1:0]     w [3],
  output vn3_pkg::oct_ctl_t           ctl_out,
  output logic [vn3_pkg::PROD_W-1:0]  prod
);
  import vn3_pkg::*;

  oct_ctl_t          x_ctl_r;
  oct_ctl_t          y_ctl_r;
  oct_ctl_t          z_ctl_r;
  oct_ctl_t          p_ctl_r;
  logic [VAL_W-1:0]  x_val_r [4];
  logic [VAL_W-1:0]  y_val_r [2];
  logic [VAL_W-1:0]  z_val_r;
  logic [W_W-1:0]    x_wy_r;
  logic [W_W-1:0]    x_wz_r;
  logic [W_W-1:0]    y_wz_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_ctl_r.valid <= 1'b0;
      y_ctl_r.valid <= 1'b0;
      z_ctl_r.valid <= 1'b0;
      p_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      x_ctl_r <= ctl_in;
      y_ctl_r <= x_ctl_r;
      z_ctl_r <= y_ctl_r;
      p_ctl_r <= z_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        x_val_r[i] <= blend(corner[2*i], corner[2*i+1], w[0]);
      end
      x_wy_r <= w[1];
      x_wz_r <= w[2];
      for (int j = 0; j < 2; j++) begin
        y_val_r[j] <= blend(x_val_r[2*j], x_val_r[2*j+1], x_wy_r);
      end
      y_wz_r  <= x_wz_r;
      z_val_r <= blend(y_val_r[0], y_val_r[1], y_wz_r);
      prod_r  <= PROD_W'(z_ctl_r.amp) * PROD_W'(z_val_r);
    end
  end

  assign ctl_out = p_ctl_r;
  assign prod    = prod_r;

endmodule

>>> sv/vn3_div.sv
// vn3_div: octave accumulator and pipelined restoring divider, one quotient bit a stage
// uses vn3_pkg widths and octave control struct
module vn3_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  vn3_pkg::oct_ctl_t           ctl_in,
  input  logic [vn3_pkg::PROD_W-1:0]  prod,
  output logic                        res_valid,
  output logic [vn3_pkg::VAL_W-1:0]   res
);
  import vn3_pkg::*;

  logic [SUM_W-1:0] acc_sum_r;
  logic [TOT_W-1:0] acc_tot_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [TOT_W-1:0] tot_nxt;
  logic             v_r   [DIV_STAGES+1];
  logic [SUM_W-1:0] rem_r [DIV_STAGES+1];
  logic [TOT_W-1:0] den_r [DIV_STAGES+1];
  logic [VAL_W-1:0] q_r   [DIV_STAGES+1];

  always_comb begin
    sum_nxt = ctl_in.first ? SUM_W'(prod) : acc_sum_r + SUM_W'(prod);
    tot_nxt = ctl_in.first ? TOT_W'(ctl_in.amp) : acc_tot_r + TOT_W'(ctl_in.amp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= ctl_in.valid && ctl_in.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl_in.valid) begin
        acc_sum_r <= sum_nxt;
        acc_tot_r <= tot_nxt;
      end
      rem_r[0] <= sum_nxt + SUM_W'(tot_nxt >> 1);
      den_r[0] <= tot_nxt;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    localparam int BITPOS = DIV_STAGES - k;
    logic [SUM_W+VAL_W-1:0] dsh;
    logic                   ge;

    assign dsh = (SUM_W+VAL_W)'(den_r[k-1]) << BITPOS;
    assign ge  = (SUM_W+VAL_W)'(rem_r[k-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? rem_r[k-1] - dsh[SUM_W-1:0] : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        q_r[k]   <= {q_r[k-1][VAL_W-2:0], ge};
      end
    end
  end

  assign res_valid = v_r[DIV_STAGES];
  assign res       = q_r[DIV_STAGES];

endmodule

>>> sv/value_noise_3d_octave_cosine.sv
// value_noise_3d_octave_cosine: fractal 3d value noise, cosine blend, octave sum
// instantiates vn3_lattice, vn3_interp, vn3_div; uses vn3_pkg
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    opcode, pos_x, pos_y, pos_z, lattice_value
//   out      output     out_valid / out_ready  noise_out
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a lattice write does not hold the input; an evaluate request holds the input while
// its octaves (1 to 8) issue, fed by the octave sequencer one octave a cycle unless stalled;
// after the last octave issue the result passes axis, bank read, three blends,
// product, accumulate and 16 divider stages; reset is synchronous, the
// lattice is not cleared; a stalled output freezes the whole pipeline
module value_noise_3d_octave_cosine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [vn3_pkg::POS_W-1:0]      in_pos_x,
  input  logic [vn3_pkg::POS_W-1:0]      in_pos_y,
  input  logic [vn3_pkg::POS_W-1:0]      in_pos_z,
  input  logic [vn3_pkg::VAL_W-1:0]      in_lattice_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vn3_pkg::VAL_W-1:0]      out_noise_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vn3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vn3_pkg::CFG_W-1:0]      cfg_data
);
  import vn3_pkg::*;

  localparam int IW2 = SC_W - 16;

  logic [OC_W-1:0]        oc_r;
  logic [CFG_W-1:0]       pers_r;
  logic [CFG_W-1:0]       inv_r;

  logic                   adv;
  logic                   ev_acc;
  logic                   wr_acc;
  logic [OCT_W-1:0]       last_oct_c;
  logic [AMP_W+15:0]      amp_prod;
  logic [AMP_W-1:0]       amp_nxt;

  logic                   busy_r;
  logic [OCT_W-1:0]       nxt_oct_r;
  logic [OCT_W-1:0]       last_oct_r;
  logic [AMP_W-1:0]       nxt_amp_r;
  logic [POS_W-1:0]       sv_pos_r [3];

  logic                   wr_v_r;
  logic [POS_W-1:0]       wr_pos_r [3];
  logic [VAL_W-1:0]       wr_data_r;

  oct_ctl_t               s0_ctl_r;
  logic [OCT_W-1:0]       s0_oct_r;
  logic [POS_W-1:0]       s0_pos_r [3];

  logic [SC_W-1:0]        scaled [3];
  logic [IW2-1:0]         idx [3];
  logic [IW2-1:0]         idx_inc [3];
  logic [IDX_W-1:0]       lo_nxt [3];
  logic [IDX_W-1:0]       hi_nxt [3];
  logic [W_W-1:0]         w_nxt [3];

  oct_ctl_t               s1_ctl_r;
  logic [IDX_W-1:0]       s1_lo_r [3];
  logic [IDX_W-1:0]       s1_hi_r [3];
  logic [W_W-1:0]         s1_w_r [3];

  oct_ctl_t               s2_ctl_r;
  logic [W_W-1:0]         s2_w_r [3];
  logic [VAL_W-1:0]       corner [8];

  oct_ctl_t               ip_ctl;
  logic [PROD_W-1:0]      ip_prod;

  assign adv       = ~out_valid | out_ready;
  assign in_ready  = adv & ~busy_r;
  assign cfg_ready = 1'b1;
  assign ev_acc    = in_valid & in_ready & (in_opcode == OPC_EVAL);
  assign wr_acc    = in_valid & in_ready & (in_opcode == OPC_WRITE);

  always_comb begin
    if (oc_r == '0) begin
      last_oct_c = '0;
    end else if (int'(oc_r) > MAX_OCTAVES) begin
      last_oct_c = OCT_W'(MAX_OCTAVES - 1);
    end else begin
      last_oct_c = OCT_W'(oc_r - 1'b1);
    end
    amp_prod = (AMP_W+16)'(nxt_amp_r) * (AMP_W+16)'(pers_r);
    amp_nxt  = amp_prod[AMP_W+15:16];
  end

  // config registers and octave sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r           <= OC_W'(4);
      pers_r         <= CFG_W'(32768);
      inv_r          <= CFG_W'(8192);
      busy_r         <= 1'b0;
      s0_ctl_r.valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_OCTAVES:  oc_r   <= cfg_data[OC_W-1:0];
          CFG_PERSIST:  pers_r <= cfg_data;
          CFG_INV_STEP: inv_r  <= cfg_data;
          default: ;
        endcase
      end
      if (adv) begin
        if (busy_r) begin
          s0_ctl_r.valid <= 1'b1;
          s0_ctl_r.first <= 1'b0;
          s0_ctl_r.last  <= (nxt_oct_r == last_oct_r);
          s0_ctl_r.amp   <= nxt_amp_r;
          s0_oct_r       <= nxt_oct_r;
          s0_pos_r       <= sv_pos_r;
          busy_r         <= (nxt_oct_r != last_oct_r);
          nxt_oct_r      <= OCT_W'(nxt_oct_r + 1'b1);
          nxt_amp_r      <= amp_nxt;
        end else if (ev_acc) begin
          s0_ctl_r.valid <= 1'b1;
          s0_ctl_r.first <= 1'b1;
          s0_ctl_r.last  <= (last_oct_c == '0);
          s0_ctl_r.amp   <= ONE_Q16;
          s0_oct_r       <= '0;
          s0_pos_r[0]    <= in_pos_x;
          s0_pos_r[1]    <= in_pos_y;
          s0_pos_r[2]    <= in_pos_z;
          sv_pos_r[0]    <= in_pos_x;
          sv_pos_r[1]    <= in_pos_y;
          sv_pos_r[2]    <= in_pos_z;
          nxt_oct_r      <= OCT_W'(1);
          nxt_amp_r      <= AMP_W'(pers_r);
          last_oct_r     <= last_oct_c;
          busy_r         <= (last_oct_c != '0);
        end else begin
          s0_ctl_r.valid <= 1'b0;
        end
      end
    end
  end

  // axis scaling, clamp and weight lookup
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      scaled[a]  = (SC_W'(s0_pos_r[a]) << s0_oct_r) * SC_W'(inv_r);
      idx[a]     = scaled[a][SC_W-1:16];
      idx_inc[a] = idx[a] + IW2'(1);
      lo_nxt[a]  = (idx[a] > IW2'(LATTICE_DIM - 1)) ? IDX_W'(LATTICE_DIM - 1)
                                                    : idx[a][IDX_W-1:0];
      hi_nxt[a]  = (idx[a] >= IW2'(LATTICE_DIM - 1)) ? IDX_W'(LATTICE_DIM - 1)
                                                     : idx_inc[a][IDX_W-1:0];
      w_nxt[a]   = WROM[scaled[a][15 -: COS_TABLE_BITS]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.valid <= 1'b0;
      s2_ctl_r.valid <= 1'b0;
      wr_v_r         <= 1'b0;
    end else if (adv) begin
      s1_ctl_r <= s0_ctl_r;
      s2_ctl_r <= s1_ctl_r;
      wr_v_r   <= wr_acc;
    end
  end

  // lattice write goes through a register before it lands so earlier evaluates read the old word
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lo_r     <= lo_nxt;
      s1_hi_r     <= hi_nxt;
      s1_w_r      <= w_nxt;
      s2_w_r      <= s1_w_r;
      wr_pos_r[0] <= in_pos_x;
      wr_pos_r[1] <= in_pos_y;
      wr_pos_r[2] <= in_pos_z;
      wr_data_r   <= in_lattice_value;
    end
  end

  vn3_lattice u_lattice (
    .clk     (clk),
    .adv     (adv),
    .we      (wr_v_r & adv),
    .wr_x    (wr_pos_r[0]),
    .wr_y    (wr_pos_r[1]),
    .wr_z    (wr_pos_r[2]),
    .wr_data (wr_data_r),
    .lo      (s1_lo_r),
    .hi      (s1_hi_r),
    .corner  (corner)
  );

  vn3_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_in  (s2_ctl_r),
    .corner  (corner),
    .w       (s2_w_r),
    .ctl_out (ip_ctl),
    .prod    (ip_prod)
  );

  vn3_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl_in    (ip_ctl),
    .prod      (ip_prod),
    .res_valid (out_valid),
    .res       (out_noise_out)
  );

endmodule
